[design/fbc64_pkg.sv]
`timescale 1ns / 1ps
package fbc64_pkg;

    localparam int NUM_ROUNDS = 16;
    localparam int KEY_W      = 64;
    localparam int BLOCK_W    = 64;
    localparam int WORD_W     = 16;
    localparam int SK_BYTES   = 12;

    // Configuration register indexes
    localparam logic CFG_KEY  = 1'b0;
    localparam logic CFG_MODE = 1'b1;

    // Four 16-bit words of the block, first word in the high bits
    typedef struct packed {
        logic [WORD_W-1:0] w0;
        logic [WORD_W-1:0] w1;
        logic [WORD_W-1:0] w2;
        logic [WORD_W-1:0] w3;
    } words_t;

    // Twelve subkey bytes of one round, byte i at index i
    typedef logic [SK_BYTES-1:0][7:0] rkey_t;

    localparam logic [7:0] SBOX [256] = '{
        8'ha3,8'hd7,8'h09,8'h83,8'hf8,8'h48,8'hf6,8'hf4,
        8'hb3,8'h21,8'h15,8'h78,8'h99,8'hb1,8'haf,8'hf9,
        8'he7,8'h2d,8'h4d,8'h8a,8'hce,8'h4c,8'hca,8'h2e,
        8'h52,8'h95,8'hd9,8'h1e,8'h4e,8'h38,8'h44,8'h28,
        8'h0a,8'hdf,8'h02,8'ha0,8'h17,8'hf1,8'h60,8'h68,
        8'h12,8'hb7,8'h7a,8'hc3,8'he9,8'hfa,8'h3d,8'h53,
        8'h96,8'h84,8'h6b,8'hba,8'hf2,8'h63,8'h9a,8'h19,
        8'h7c,8'hae,8'he5,8'hf5,8'hf7,8'h16,8'h6a,8'ha2,
        8'h39,8'hb6,8'h7b,8'h0f,8'hc1,8'h93,8'h81,8'h1b,
        8'hee,8'hb4,8'h1a,8'hea,8'hd0,8'h91,8'h2f,8'hb8,
        8'h55,8'hb9,8'hda,8'h85,8'h3f,8'h41,8'hbf,8'he0,
        8'h5a,8'h58,8'h80,8'h5f,8'h66,8'h0b,8'hd8,8'h90,
        8'h35,8'hd5,8'hc0,8'ha7,8'h33,8'h06,8'h65,8'h69,
        8'h45,8'h00,8'h94,8'h56,8'h6d,8'h98,8'h9b,8'h76,
        8'h97,8'hfc,8'hb2,8'hc2,8'hb0,8'hfe,8'hdb,8'h20,
        8'he1,8'heb,8'hd6,8'he4,8'hdd,8'h47,8'h4a,8'h1d,
        8'h42,8'hed,8'h9e,8'h6e,8'h49,8'h3c,8'hcd,8'h43,
        8'h27,8'hd2,8'h07,8'hd4,8'hde,8'hc7,8'h67,8'h18,
        8'h89,8'hcb,8'h30,8'h1f,8'h8d,8'hc6,8'h8f,8'haa,
        8'hc8,8'h74,8'hdc,8'hc9,8'h5d,8'h5c,8'h31,8'ha4,
        8'h70,8'h88,8'h61,8'h2c,8'h9f,8'h0d,8'h2b,8'h87,
        8'h50,8'h82,8'h54,8'h64,8'h26,8'h7d,8'h03,8'h40,
        8'h34,8'h4b,8'h1c,8'h73,8'hd1,8'hc4,8'hfd,8'h3b,
        8'hcc,8'hfb,8'h7f,8'hab,8'he6,8'h3e,8'h5b,8'ha5,
        8'had,8'h04,8'h23,8'h9c,8'h14,8'h51,8'h22,8'hf0,
        8'h29,8'h79,8'h71,8'h7e,8'hff,8'h8c,8'h0e,8'he2,
        8'h0c,8'hef,8'hbc,8'h72,8'h75,8'h6f,8'h37,8'ha1,
        8'hec,8'hd3,8'h8e,8'h62,8'h8b,8'h86,8'h10,8'he8,
        8'h08,8'h77,8'h11,8'hbe,8'h92,8'h4f,8'h24,8'hc5,
        8'h32,8'h36,8'h9d,8'hcf,8'hf3,8'ha6,8'hbb,8'hac,
        8'h5e,8'h6c,8'ha9,8'h13,8'h57,8'h25,8'hb5,8'he3,
        8'hbd,8'ha8,8'h3a,8'h01,8'h05,8'h59,8'h2a,8'h46
    };

    // Subkey bytes of encryption round er: each byte is taken from the key
    // rotated left by one more bit than the byte before it.
    function automatic rkey_t round_subkeys(logic [KEY_W-1:0] key, int er);
        rkey_t           sk;
        logic [KEY_W-1:0] rk;
        int              s;
        int              bsel;
        int              i;
        for (i = 0; i < SK_BYTES; i++) begin
            s    = (12 * er + i + 1) & 63;
            bsel = (4 * er + (i & 3)) & 7;
            if (s == 0) begin
                rk = key;
            end else begin
                rk = (key << s) | (key >> (KEY_W - s));
            end
            sk[i] = rk[8*bsel +: 8];
        end
        return sk;
    endfunction

endpackage

[design/fbc64_round.sv]
`timescale 1ns / 1ps
module fbc64_round
    import fbc64_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   adv,
    input  logic   decrypt,
    input  rkey_t  sk,
    input  logic   in_valid,
    input  words_t in_words,
    output logic   out_valid,
    output words_t out_words
);

    // First half registers: partial G state for both permutations
    logic              mid_valid_reg;
    words_t            mid_words_reg;
    logic [7:0]        c0_reg, d0_reg, c1_reg, d1_reg;
    logic [7:0]        c0_next, d0_next, c1_next, d1_next;

    // Second half registers
    logic              out_valid_reg;
    words_t            out_words_reg;
    words_t            out_words_next;

    // Second half intermediate values
    logic [7:0]        e0, f0b, e1, f1b;
    logic [WORD_W-1:0] t0, t1, f0, f1, n0, n1, x0, x1;

    // First two S-box steps of each G permutation
    always_comb begin
        c0_next = SBOX[in_words.w0[7:0] ^ sk[0]] ^ in_words.w0[15:8];
        d0_next = SBOX[c0_next ^ sk[1]] ^ in_words.w0[7:0];
        c1_next = SBOX[in_words.w1[7:0] ^ sk[4]] ^ in_words.w1[15:8];
        d1_next = SBOX[c1_next ^ sk[5]] ^ in_words.w1[7:0];
    end

    // Last two S-box steps, F mixing and the Feistel update
    always_comb begin
        e0  = SBOX[d0_reg ^ sk[2]] ^ c0_reg;
        f0b = SBOX[e0 ^ sk[3]] ^ d0_reg;
        e1  = SBOX[d1_reg ^ sk[6]] ^ c1_reg;
        f1b = SBOX[e1 ^ sk[7]] ^ d1_reg;
        t0  = {e0, f0b};
        t1  = {e1, f1b};
        f0  = t0 + {t1[WORD_W-2:0], 1'b0} + {sk[8], sk[9]};
        f1  = {t0[WORD_W-2:0], 1'b0} + t1 + {sk[10], sk[11]};
        x0  = mid_words_reg.w2 ^ f0;
        x1  = mid_words_reg.w3 ^ f1;
        if (decrypt) begin
            n0 = {mid_words_reg.w2[WORD_W-2:0], mid_words_reg.w2[WORD_W-1]} ^ f0;
            n1 = {x1[0], x1[WORD_W-1:1]};
        end else begin
            n0 = {x0[0], x0[WORD_W-1:1]};
            n1 = {mid_words_reg.w3[WORD_W-2:0], mid_words_reg.w3[WORD_W-1]} ^ f1;
        end
        out_words_next.w0 = n0;
        out_words_next.w1 = n1;
        out_words_next.w2 = mid_words_reg.w0;
        out_words_next.w3 = mid_words_reg.w1;
    end

    // Advance valid bits with the pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            mid_valid_reg <= in_valid;
            out_valid_reg <= mid_valid_reg;
        end
    end

    // Advance payload; hold on stall
    always_ff @(posedge aclk) begin
        if (adv) begin
            mid_words_reg <= in_words;
            c0_reg        <= c0_next;
            d0_reg        <= d0_next;
            c1_reg        <= c1_next;
            d1_reg        <= d1_next;
            out_words_reg <= out_words_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_words = out_words_reg;

endmodule

[design/feistel_block_cipher_64.sv]
`timescale 1ns / 1ps
// 64-bit Feistel block cipher (16 rounds, 64-bit key, S-box based F function).
// Write the key at index 0 and the mode at index 1 (0 encrypts, 1 decrypts)
// while no block is in flight. The core is a fully unrolled pipeline with two
// register stages per round, each holding two dependent S-box lookups, plus
// an output register: it takes one block per cycle while s_ready is high. A
// skid register behind the pipeline lets the input keep accepting while a
// result waits; s_ready drops only while that skid register holds a block.
module feistel_block_cipher_64
    import fbc64_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [KEY_W-1:0]   cfg_data,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic [BLOCK_W-1:0] s_block_in,

    output logic               m_valid,
    input  logic               m_ready,
    output logic [BLOCK_W-1:0] m_block_out
);

    logic [KEY_W-1:0]   key_reg;
    logic               decrypt_reg;

    logic               adv;
    logic               stage_valid [NUM_ROUNDS+1];
    words_t             stage_words [NUM_ROUNDS+1];
    words_t             kw;
    logic [BLOCK_W-1:0] pipe_block;
    logic               pipe_valid;

    logic               out_valid_reg, out_valid_next;
    logic [BLOCK_W-1:0] out_block_reg, out_block_next;
    logic               skid_valid_reg, skid_valid_next;
    logic [BLOCK_W-1:0] skid_block_reg;
    logic               skid_load;

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg     <= '0;
            decrypt_reg <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_KEY:  key_reg     <= cfg_data;
                CFG_MODE: decrypt_reg <= cfg_data[0];
                default:  ;
            endcase
        end
    end

    // Whitening words, high word first
    assign kw = words_t'(key_reg);

    // Input whitening feeds the first round
    assign adv            = !skid_valid_reg;
    assign s_ready        = adv;
    assign stage_valid[0] = s_valid;
    assign stage_words[0] = words_t'(s_block_in) ^ kw;

    // Round pipeline; decryption runs the subkeys in reverse round order
    for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_round
        rkey_t sk_enc, sk_dec, sk;
        assign sk_enc = round_subkeys(key_reg, r);
        assign sk_dec = round_subkeys(key_reg, NUM_ROUNDS - 1 - r);
        assign sk     = decrypt_reg ? sk_dec : sk_enc;

        fbc64_round u_round (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .decrypt   (decrypt_reg),
            .sk        (sk),
            .in_valid  (stage_valid[r]),
            .in_words  (stage_words[r]),
            .out_valid (stage_valid[r+1]),
            .out_words (stage_words[r+1])
        );
    end

    // Swap halves and whiten on the way out
    assign pipe_valid = stage_valid[NUM_ROUNDS] && adv;
    assign pipe_block = {stage_words[NUM_ROUNDS].w2 ^ kw.w0,
                         stage_words[NUM_ROUNDS].w3 ^ kw.w1,
                         stage_words[NUM_ROUNDS].w0 ^ kw.w2,
                         stage_words[NUM_ROUNDS].w1 ^ kw.w3};

    // Output register and skid: drain the skid first, else take the pipe
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_block_next  = out_block_reg;
        skid_valid_next = skid_valid_reg;
        skid_load       = 1'b0;
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_block_next  = skid_block_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = pipe_valid;
                out_block_next = pipe_block;
            end
        end else if (pipe_valid) begin
            skid_valid_next = 1'b1;
            skid_load       = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_block_reg <= out_block_next;
        if (skid_load) begin
            skid_block_reg <= pipe_block;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_block_out = out_block_reg;

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
module testbench;
    import fbc64_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int MAX_PRINTED    = 40;
    localparam int BLOCKS_PER_SEG = 88;

    // Expected ciphertext/plaintext store with its own copy of the key and mode
    class cipher_scoreboard;
        logic [KEY_W-1:0]   key;
        logic               mode;
        logic [BLOCK_W-1:0] expected_blocks[$];
        int                 errors;
        int                 checked;

        function new();
            key     = '0;
            mode    = 1'b0;
            errors  = 0;
            checked = 0;
        endfunction

        function void write_reg(logic idx, logic [KEY_W-1:0] data);
            if (idx == CFG_KEY) begin
                key = data;
            end else begin
                mode = data[0];
            end
        endfunction

        // Subkey byte pos of encryption round er
        function logic [7:0] key_byte(int er, int pos);
            logic [KEY_W-1:0] rk;
            int               sh;
            int               bsel;
            sh   = (12 * er + pos + 1) % 64;
            rk   = (sh == 0) ? key : ((key << sh) | (key >> (64 - sh)));
            bsel = (4 * er + (pos % 4)) % 8;
            return rk[8*bsel +: 8];
        endfunction

        // Byte permutation through four S-box lookups
        function logic [15:0] g_mix(logic [15:0] w, int er, int base);
            logic [7:0] c;
            logic [7:0] d;
            logic [7:0] e;
            logic [7:0] f;
            c = SBOX[w[7:0] ^ key_byte(er, base)] ^ w[15:8];
            d = SBOX[c ^ key_byte(er, base + 1)] ^ w[7:0];
            e = SBOX[d ^ key_byte(er, base + 2)] ^ c;
            f = SBOX[e ^ key_byte(er, base + 3)] ^ d;
            return {e, f};
        endfunction

        function logic [BLOCK_W-1:0] transform(logic [BLOCK_W-1:0] blk);
            logic [15:0] kw[4];
            logic [15:0] r[4];
            logic [15:0] t0;
            logic [15:0] t1;
            logic [15:0] f0;
            logic [15:0] f1;
            logic [15:0] n0;
            logic [15:0] n1;
            logic [15:0] x;
            int          er;
            for (int j = 0; j < 4; j++) begin
                kw[j] = key[63-16*j -: 16];
                r[j]  = blk[63-16*j -: 16] ^ kw[j];
            end
            for (int rnd = 0; rnd < NUM_ROUNDS; rnd++) begin
                er = mode ? (15 - rnd) : rnd;
                t0 = g_mix(r[0], er, 0);
                t1 = g_mix(r[1], er, 4);
                f0 = t0 + (t1 << 1) + {key_byte(er, 8), key_byte(er, 9)};
                f1 = (t0 << 1) + t1 + {key_byte(er, 10), key_byte(er, 11)};
                if (!mode) begin
                    x  = r[2] ^ f0;
                    n0 = {x[0], x[15:1]};
                    n1 = {r[3][14:0], r[3][15]} ^ f1;
                end else begin
                    n0 = {r[2][14:0], r[2][15]} ^ f0;
                    x  = r[3] ^ f1;
                    n1 = {x[0], x[15:1]};
                end
                r[2] = r[0];
                r[3] = r[1];
                r[0] = n0;
                r[1] = n1;
            end
            return {r[2] ^ kw[0], r[3] ^ kw[1], r[0] ^ kw[2], r[1] ^ kw[3]};
        endfunction

        function void note_block(logic [BLOCK_W-1:0] blk);
            expected_blocks.push_back(transform(blk));
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= MAX_PRINTED) begin
                $display("mismatch: %s", msg);
            end
        endtask

        task check_block(logic [BLOCK_W-1:0] got);
            logic [BLOCK_W-1:0] want;
            if (expected_blocks.size() == 0) begin
                report_mismatch($sformatf("unexpected block %h", got));
            end else begin
                want = expected_blocks.pop_front();
                checked++;
                if (got !== want) begin
                    report_mismatch($sformatf("block_out %h, want %h", got, want));
                end
            end
        endtask

        function int pending();
            return expected_blocks.size();
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               cfg_valid;
    logic               cfg_ready;
    logic               cfg_index;
    logic [KEY_W-1:0]   cfg_data;
    logic               s_valid;
    logic               s_ready;
    logic [BLOCK_W-1:0] s_block_in;
    logic               m_valid;
    logic               m_ready;
    logic [BLOCK_W-1:0] m_block_out;

    cipher_scoreboard sb = new();

    int send_idle_pct;
    int recv_stall_pct;
    int idle_cycles;
    int blocks_sent;
    int settings_used;

    feistel_block_cipher_64 u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_block_in  (s_block_in),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_block_out (m_block_out)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Stall the result side at random
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Note accepted blocks and check accepted results
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_block(s_block_in);
            end
            if (m_valid && m_ready) begin
                sb.check_block(m_block_out);
            end
        end
    end

    // End the run when no handshake happens for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", idle_cycles);
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Write one register; call at a falling edge
    task automatic cfg_write(logic idx, logic [KEY_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Offer one item after a random gap; call and return at a falling edge
    task automatic send_block(logic [BLOCK_W-1:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_block_in <= data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        blocks_sent++;
        @(negedge aclk);
    endtask

    // Drop valid and wait until every result is back
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() > 0) @(negedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [BLOCK_W-1:0] pick_block();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            2:       return 64'h1 << $urandom_range(63);
            default: return rand64();
        endcase
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return 64'h1 << $urandom_range(63);
            default: return rand64();
        endcase
    endfunction

    task automatic new_setting();
        if ($urandom_range(1)) begin
            cfg_write(CFG_KEY, pick_key());
            cfg_write(CFG_MODE, rand64());
        end else begin
            cfg_write(CFG_MODE, rand64());
            cfg_write(CFG_KEY, pick_key());
        end
        settings_used++;
    endtask

    initial begin
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_KEY;
        cfg_data       = '0;
        s_valid        = 1'b0;
        s_block_in     = '0;
        m_ready        = 1'b0;
        send_idle_pct  = 15;
        recv_stall_pct = 15;
        idle_cycles    = 0;
        blocks_sent    = 0;
        settings_used  = 1;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: reset key and mode first, then key and mode extremes
        send_block('0);
        send_block('1);
        send_block(64'h0123_4567_89ab_cdef);
        send_block(64'haaaa_aaaa_aaaa_aaaa);
        send_block(64'h5555_5555_5555_5555);
        send_block(64'h8000_0000_0000_0000);
        send_block(64'h0000_0000_0000_0001);
        drain();
        cfg_write(CFG_KEY, '1);
        send_block('0);
        send_block('1);
        send_block(64'hffff_0000_ffff_0000);
        drain();
        cfg_write(CFG_MODE, 64'h1);
        send_block('0);
        send_block('1);
        send_block(64'h0000_ffff_0000_ffff);
        drain();
        cfg_write(CFG_KEY, '0);
        send_block('1);
        send_block(64'hfedc_ba98_7654_3210);
        drain();
        // Upper bits of the mode word are ignored
        cfg_write(CFG_MODE, 64'hffff_ffff_ffff_fffe);
        cfg_write(CFG_KEY, 64'h0123_4567_89ab_cdef);
        send_block(64'h0123_4567_89ab_cdef);
        send_block('0);
        drain();
        cfg_write(CFG_MODE, 64'h8000_0000_0000_0001);
        send_block(64'h0123_4567_89ab_cdef);
        send_block('1);
        drain();
        settings_used += 6;

        // Random: four pressure mixes, two settings each
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            for (int seg = 0; seg < 2; seg++) begin
                drain();
                new_setting();
                for (int n = 0; n < BLOCKS_PER_SEG; n++) begin
                    send_block(pick_block());
                end
            end
        end

        // Let everything come back, then allow for the pipeline depth
        s_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.pending() > 0) begin
            sb.report_mismatch($sformatf("%0d blocks never came back", sb.pending()));
        end

        $display("run: %0d blocks sent, %0d results checked, %0d mismatches",
                 blocks_sent, sb.checked, sb.errors);
        $display("run: %0d key/mode settings under four stall mixes", settings_used);
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
